// ===== src/ibab_pkg.sv =====
// Shared constants and types for the image block average binning unit.
package ibab_pkg;

    // Line store geometry and sample format.
    localparam int MAX_WIDTH   = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_EXP     = 7;
    localparam int ACC_BITS    = SAMPLE_BITS + 2 * MAX_EXP;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = 12;
    localparam int PLANE_BITS  = 8;
    localparam int EXP_BITS    = 3;
    localparam int SHIFT_BITS  = EXP_BITS + 1;
    localparam int SIZE_BITS   = 13;
    localparam int COUNT_BITS  = 9;
    localparam int CFG_BITS    = 13;
    localparam int CFG_IDX_BITS = 3;

    // Size limits and values after reset.
    localparam logic [SIZE_BITS-1:0]  WIDTH_LIMIT   = SIZE_BITS'(MAX_WIDTH);
    localparam logic [SIZE_BITS-1:0]  HEIGHT_LIMIT  = SIZE_BITS'(4096);
    localparam logic [COUNT_BITS-1:0] PLANE_LIMIT   = COUNT_BITS'(256);
    localparam logic [SIZE_BITS-1:0]  WIDTH_RESET   = SIZE_BITS'(4096);
    localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET  = SIZE_BITS'(4096);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET   = COUNT_BITS'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PLANE_WIDTH  = 3'd0,
        CFG_PLANE_HEIGHT = 3'd1,
        CFG_PLANE_COUNT  = 3'd2,
        CFG_X_EXPONENT   = 3'd3,
        CFG_Y_EXPONENT   = 3'd4
    } cfg_index_t;

    // Control carried with a pixel from the read stage to the update stage.
    typedef struct packed {
        logic                  pass;
        logic                  write;
        logic                  first;
        logic                  emit;
        logic [COL_BITS-1:0]   addr;
        logic [SHIFT_BITS-1:0] shift;
        logic                  row_end;
        logic                  plane_end;
        logic                  map_end;
    } stage_ctrl_t;

endpackage

// ===== src/image_block_average_binning_unit.sv =====
// Top level: block average binning over a line store of column accumulators.
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  pixel     in_valid, in_stall, sample                in
//  result    out_valid, out_stall, binned_value,        out
//            row_end, plane_end, map_end
//  config    cfg_write_en, cfg_index, cfg_data         in
//
// One pixel is accepted per clock unless stalled; a result passes the update stage
// and the output register. The accumulator memory is read on accept and written back
// when the pixel leaves the update stage; a same-address write of the previous pixel
// is forwarded. No clearing pass is needed after reset; a block's first pixel ignores
// the stored sum. A stalled output holds the update stage, which in turn stalls the input.
module image_block_average_binning_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ibab_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ibab_pkg::SAMPLE_BITS-1:0] binned_value,
    output logic                                  row_end,
    output logic                                  plane_end,
    output logic                                  map_end,
    input  logic                                  cfg_write_en,
    input  logic [ibab_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ibab_pkg::CFG_BITS-1:0]         cfg_data
);

    // Configuration registers.
    logic [ibab_pkg::SIZE_BITS-1:0]  width_reg;
    logic [ibab_pkg::SIZE_BITS-1:0]  height_reg;
    logic [ibab_pkg::COUNT_BITS-1:0] count_reg;
    logic [ibab_pkg::EXP_BITS-1:0]   xexp_reg;
    logic [ibab_pkg::EXP_BITS-1:0]   yexp_reg;

    // Raster position counters.
    logic [ibab_pkg::COL_BITS-1:0]   col_reg, col_next;
    logic [ibab_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic [ibab_pkg::PLANE_BITS-1:0] plane_reg, plane_next;

    // Update stage.
    logic                                  s1_valid_reg, s1_valid_next;
    ibab_pkg::stage_ctrl_t                 s1_ctrl_reg, s1_ctrl_next;
    logic signed [ibab_pkg::SAMPLE_BITS-1:0] s1_sample_reg;

    // Accumulator memory and forwarding path.
    logic signed [ibab_pkg::ACC_BITS-1:0] sums_mem [ibab_pkg::MAX_WIDTH];
    logic signed [ibab_pkg::ACC_BITS-1:0] rd_data_reg;
    logic                                 fwd_valid_reg;
    logic [ibab_pkg::COL_BITS-1:0]        fwd_addr_reg;
    logic signed [ibab_pkg::ACC_BITS-1:0] fwd_data_reg;

    // Output register.
    logic                                  out_valid_reg;
    logic signed [ibab_pkg::SAMPLE_BITS-1:0] out_value_reg;
    logic                                  out_row_end_reg;
    logic                                  out_plane_end_reg;
    logic                                  out_map_end_reg;

    // Combinational signals.
    logic                                  accept;
    logic                                  out_free;
    logic                                  s1_go;
    logic                                  mem_we;
    logic [ibab_pkg::SIZE_BITS-1:0]        w_eff;
    logic [ibab_pkg::SIZE_BITS-1:0]        h_eff;
    logic [ibab_pkg::COUNT_BITS-1:0]       p_eff;
    logic [ibab_pkg::COL_BITS-1:0]         x_mask;
    logic [ibab_pkg::ROW_BITS-1:0]         y_mask;
    logic [ibab_pkg::SIZE_BITS-1:0]        out_w;
    logic [ibab_pkg::SIZE_BITS-1:0]        out_h;
    logic [ibab_pkg::COL_BITS-1:0]         out_col;
    logic [ibab_pkg::ROW_BITS-1:0]         out_row;
    logic                                  last_col;
    logic                                  last_row;
    logic                                  last_pl;
    logic                                  in_block;
    logic                                  blk_row_end;
    logic                                  blk_plane_end;
    logic signed [ibab_pkg::ACC_BITS-1:0]  acc_base;
    logic signed [ibab_pkg::ACC_BITS-1:0]  acc_sum;
    logic signed [ibab_pkg::ACC_BITS-1:0]  acc_avg;
    logic signed [ibab_pkg::SAMPLE_BITS-1:0] result_value;

    // Handshake and stage flow.
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        s1_go    = s1_valid_reg && (!s1_ctrl_reg.emit || out_free);
        in_stall = s1_valid_reg && !s1_go;
        accept   = in_valid && !in_stall;
        mem_we   = s1_go && s1_ctrl_reg.write;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Effective sizes and block geometry.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = ibab_pkg::SIZE_BITS'(1);
        end
        else if (width_reg > ibab_pkg::WIDTH_LIMIT)
        begin
            w_eff = ibab_pkg::WIDTH_LIMIT;
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            h_eff = ibab_pkg::SIZE_BITS'(1);
        end
        else if (height_reg > ibab_pkg::HEIGHT_LIMIT)
        begin
            h_eff = ibab_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            h_eff = height_reg;
        end

        if (count_reg == '0)
        begin
            p_eff = ibab_pkg::COUNT_BITS'(1);
        end
        else if (count_reg > ibab_pkg::PLANE_LIMIT)
        begin
            p_eff = ibab_pkg::PLANE_LIMIT;
        end
        else
        begin
            p_eff = count_reg;
        end

        x_mask  = (ibab_pkg::COL_BITS'(1) << xexp_reg) - ibab_pkg::COL_BITS'(1);
        y_mask  = (ibab_pkg::ROW_BITS'(1) << yexp_reg) - ibab_pkg::ROW_BITS'(1);
        out_w   = w_eff >> xexp_reg;
        out_h   = h_eff >> yexp_reg;
        out_col = col_reg >> xexp_reg;
        out_row = row_reg >> yexp_reg;

        last_col = ({1'b0, col_reg} + ibab_pkg::SIZE_BITS'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + ibab_pkg::SIZE_BITS'(1)) >= h_eff;
        last_pl  = ({1'b0, plane_reg} + ibab_pkg::COUNT_BITS'(1)) >= p_eff;

        in_block = ({1'b0, col_reg} < (w_eff & ~{1'b0, x_mask}))
                && ({1'b0, row_reg} < (h_eff & ~{1'b0, y_mask}));
        blk_row_end   = ({1'b0, out_col} + ibab_pkg::SIZE_BITS'(1)) == out_w;
        blk_plane_end = blk_row_end
                     && (({1'b0, out_row} + ibab_pkg::SIZE_BITS'(1)) == out_h);
    end

    // Control for the pixel entering the update stage.
    always_comb
    begin
        s1_ctrl_next.pass = ((xexp_reg == '0) && (yexp_reg == '0))
                         || ((ibab_pkg::SIZE_BITS'(1) << xexp_reg) > w_eff)
                         || ((ibab_pkg::SIZE_BITS'(1) << yexp_reg) > h_eff);
        s1_ctrl_next.write = !s1_ctrl_next.pass && in_block;
        s1_ctrl_next.first = ((row_reg & y_mask) == '0) && ((col_reg & x_mask) == '0);
        s1_ctrl_next.addr  = out_col;
        s1_ctrl_next.shift = {1'b0, xexp_reg} + {1'b0, yexp_reg};
        if (s1_ctrl_next.pass)
        begin
            s1_ctrl_next.emit      = 1'b1;
            s1_ctrl_next.row_end   = last_col;
            s1_ctrl_next.plane_end = last_col && last_row;
            s1_ctrl_next.map_end   = last_col && last_row && last_pl;
        end
        else
        begin
            s1_ctrl_next.emit      = in_block && ((col_reg & x_mask) == x_mask)
                                  && ((row_reg & y_mask) == y_mask);
            s1_ctrl_next.row_end   = blk_row_end;
            s1_ctrl_next.plane_end = blk_plane_end;
            s1_ctrl_next.map_end   = blk_plane_end && last_pl;
        end
    end

    // Raster counters advance on every accepted transaction.
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next   = '0;
                    plane_next = last_pl ? '0 : plane_reg + ibab_pkg::PLANE_BITS'(1);
                end
                else
                begin
                    row_next = row_reg + ibab_pkg::ROW_BITS'(1);
                end
            end
            else
            begin
                col_next = col_reg + ibab_pkg::COL_BITS'(1);
            end
        end
    end

    // Accumulate, then scale the finished block sum.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_ctrl_reg.addr))
        begin
            acc_base = fwd_data_reg;
        end
        else
        begin
            acc_base = rd_data_reg;
        end
        if (s1_ctrl_reg.first)
        begin
            acc_sum = ibab_pkg::ACC_BITS'(s1_sample_reg);
        end
        else
        begin
            acc_sum = acc_base + ibab_pkg::ACC_BITS'(s1_sample_reg);
        end
        acc_avg = acc_sum >>> s1_ctrl_reg.shift;
        if (s1_ctrl_reg.pass)
        begin
            result_value = s1_sample_reg;
        end
        else
        begin
            result_value = acc_avg[ibab_pkg::SAMPLE_BITS-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ibab_pkg::WIDTH_RESET;
            height_reg <= ibab_pkg::HEIGHT_RESET;
            count_reg  <= ibab_pkg::COUNT_RESET;
            xexp_reg   <= '0;
            yexp_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (ibab_pkg::cfg_index_t'(cfg_index))
                ibab_pkg::CFG_PLANE_WIDTH:  width_reg  <= cfg_data;
                ibab_pkg::CFG_PLANE_HEIGHT: height_reg <= cfg_data;
                ibab_pkg::CFG_PLANE_COUNT:  count_reg  <= cfg_data[ibab_pkg::COUNT_BITS-1:0];
                ibab_pkg::CFG_X_EXPONENT:   xexp_reg   <= cfg_data[ibab_pkg::EXP_BITS-1:0];
                ibab_pkg::CFG_Y_EXPONENT:   yexp_reg   <= cfg_data[ibab_pkg::EXP_BITS-1:0];
                default:                    ;
            endcase
        end
    end

    // Control state: counters, stage valid, forwarding valid, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            plane_reg    <= plane_next;
            s1_valid_reg <= s1_valid_next;
            if (mem_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_go && s1_ctrl_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payload, forwarding data and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg   <= s1_ctrl_next;
            s1_sample_reg <= sample;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= s1_ctrl_reg.addr;
            fwd_data_reg <= acc_sum;
        end
        if (s1_go && s1_ctrl_reg.emit)
        begin
            out_value_reg     <= result_value;
            out_row_end_reg   <= s1_ctrl_reg.row_end;
            out_plane_end_reg <= s1_ctrl_reg.plane_end;
            out_map_end_reg   <= s1_ctrl_reg.map_end;
        end
    end

    // Column accumulator memory: read on accept, written back when the pixel leaves the update stage.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sums_mem[s1_ctrl_reg.addr] <= acc_sum;
        end
        if (accept)
        begin
            rd_data_reg <= sums_mem[s1_ctrl_next.addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign binned_value = out_value_reg;
    assign row_end      = out_row_end_reg;
    assign plane_end    = out_plane_end_reg;
    assign map_end      = out_map_end_reg;

`ifndef SYNTHESIS
    // An empty update stage never holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n) !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty update stage");

    // An accepted transaction occupies the update stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg)
        else $error("accepted pixel lost before update stage");

    // A result leaving the update stage shows up at the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_ctrl_reg.emit) |=> out_valid)
        else $error("emitted result missing at output");

    // Pass-through pixels never touch the accumulator memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s1_valid_reg && !s1_ctrl_reg.pass))
        else $error("memory write without a binning pixel");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the image block average binning unit.
module tb;
    import ibab_pkg::*;

    // Run limit in clock cycles, far above the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 36;
    // Cycles to let the two-stage pipeline settle when no result is pending.
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   row_end;
        logic                   plane_end;
        logic                   map_end;
    } bin_result_t;

    // One pixel waiting to be sent, with an optional hand-typed expectation.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pix;
        logic                   typed;
        bin_result_t            want;
    } pixel_item_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_index_t             reg_idx;
        logic [CFG_BITS-1:0]    reg_val;
        logic [SAMPLE_BITS-1:0] pix;
        logic                   typed;
        bin_result_t            want;
    } stim_row_t;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EXTREMES} fill_t;

    // Directed rows: extremes after reset, mid-stream register writes, zero and
    // oversized sizes, a partial block, floor rounding, full-scale sums and a
    // factor larger than the plane.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b1, '{24'h7FFFFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h800000, 1'b1, '{24'h800000, 1'b0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h000000, 1'b1, '{24'h000000, 1'b0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'hFFFFFF, 1'b1, '{24'hFFFFFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h555555, 1'b1, '{24'h555555, 1'b0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'hAAAAAA, 1'b1, '{24'hAAAAAA, 1'b0, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_PLANE_WIDTH, 13'd3, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h123456, 1'b1, '{24'h123456, 1'b1, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_PLANE_HEIGHT, 13'h1FFF, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h654321, 1'b1, '{24'h654321, 1'b0, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_PLANE_WIDTH, 13'h1FFF, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h0F0F0F, 1'b1, '{24'h0F0F0F, 1'b0, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_PLANE_WIDTH, 13'd0, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_PLANE_HEIGHT, 13'd0, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_PLANE_COUNT, 13'h1FF, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'hF0F0F0, 1'b1, '{24'hF0F0F0, 1'b1, 1'b1, 1'b0}},
        '{ROW_WRITE, CFG_PLANE_COUNT, 13'd2, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h3C3C3C, 1'b1, '{24'h3C3C3C, 1'b1, 1'b1, 1'b1}},
        '{ROW_WRITE, CFG_PLANE_WIDTH, 13'd3, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_PLANE_HEIGHT, 13'd2, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_PLANE_COUNT, 13'd1, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_X_EXPONENT, 13'd1, 24'h0, 1'b0, '0},
        '{ROW_WRITE, CFG_Y_EXPONENT, 13'd1, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'hFFFFFF, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h000000, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h000000, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h000000, 1'b1, '{24'hFFFFFF, 1'b1, 1'b1, 1'b1}},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h555555, 1'b0, '0},
        '{ROW_WRITE, CFG_PLANE_WIDTH, 13'd2, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h7FFFFF, 1'b1, '{24'h7FFFFF, 1'b1, 1'b1, 1'b1}},
        '{ROW_WRITE, CFG_X_EXPONENT, 13'd2, 24'h0, 1'b0, '0},
        '{ROW_PIXEL, CFG_PLANE_WIDTH, 13'd0, 24'h2468AC, 1'b1, '{24'h2468AC, 1'b0, 1'b0, 1'b0}}
    };

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample       = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] binned_value;
    logic                          row_end;
    logic                          plane_end;
    logic                          map_end;
    logic                          cfg_write_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index    = CFG_PLANE_WIDTH;
    logic [CFG_BITS-1:0]           cfg_data     = '0;

    // Shadow copy of the registers and the binning state.
    logic [SIZE_BITS-1:0]  reg_width  = WIDTH_RESET;
    logic [SIZE_BITS-1:0]  reg_height = HEIGHT_RESET;
    logic [COUNT_BITS-1:0] reg_count  = COUNT_RESET;
    logic [EXP_BITS-1:0]   reg_xexp   = '0;
    logic [EXP_BITS-1:0]   reg_yexp   = '0;
    longint                block_sums [MAX_WIDTH];
    int unsigned           col_pos    = 0;
    int unsigned           row_pos    = 0;
    int unsigned           plane_pos  = 0;

    pixel_item_t pixel_q [$];
    bin_result_t expected_bins [$];
    pixel_item_t held_item = '0;
    bin_result_t predicted;
    bin_result_t want_bin;
    bit          produces;
    bit          no_gaps = 1'b0;

    int unsigned errors          = 0;
    int unsigned cycles          = 0;
    int unsigned pixels_accepted = 0;
    int unsigned results_seen    = 0;
    int unsigned random_pixels   = 0;
    int unsigned frames_run      = 0;

    image_block_average_binning_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .binned_value (binned_value),
        .row_end      (row_end),
        .plane_end    (plane_end),
        .map_end      (map_end),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A zero size acts as one and an oversized one as its limit.
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the binning state by one pixel; returns 1 when a block average
    // or a pass-through pixel leaves the block.
    function automatic bit bin_pixel(input logic signed [SAMPLE_BITS-1:0] pix,
                                     output bin_result_t res);
        int unsigned w, h, p, xe, ye, ow, oh, xm, ym, oc;
        bit          last_col, last_row, last_pl, emit;
        longint      avg;
        w  = clamp_size(reg_width, WIDTH_LIMIT);
        h  = clamp_size(reg_height, HEIGHT_LIMIT);
        p  = clamp_size(reg_count, PLANE_LIMIT);
        xe = reg_xexp;
        ye = reg_yexp;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        last_pl  = (plane_pos + 1 >= p);
        emit = 1'b0;
        res  = '0;

        if ((xe == 0 && ye == 0) || (1 << xe) > w || (1 << ye) > h)
        begin
            res.value     = pix;
            res.row_end   = last_col;
            res.plane_end = last_col && last_row;
            res.map_end   = last_col && last_row && last_pl;
            emit = 1'b1;
        end
        else
        begin
            ow = w >> xe;
            oh = h >> ye;
            xm = (1 << xe) - 1;
            ym = (1 << ye) - 1;
            // Pixels right of or below the last whole block are dropped.
            if (col_pos < (ow << xe) && row_pos < (oh << ye))
            begin
                oc = col_pos >> xe;
                if ((row_pos & ym) == 0 && (col_pos & xm) == 0)
                    block_sums[oc] = pix;
                else
                    block_sums[oc] += pix;
                if ((col_pos & xm) == xm && (row_pos & ym) == ym)
                begin
                    avg = block_sums[oc] >>> (xe + ye);
                    res.value     = avg[SAMPLE_BITS-1:0];
                    res.row_end   = (oc + 1 == ow);
                    res.plane_end = res.row_end && ((row_pos >> ye) + 1 == oh);
                    res.map_end   = res.plane_end && last_pl;
                    emit = 1'b1;
                end
            end
        end

        // Raster counters wrap at or beyond their bound.
        if (last_col)
        begin
            col_pos = 0;
            if (last_row)
            begin
                row_pos   = 0;
                plane_pos = last_pl ? 0 : plane_pos + 1;
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return emit;
    endfunction

    // Pixel sender: one transaction per accepting edge, with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                produces = bin_pixel(held_item.pix, predicted);
                if (held_item.typed)
                    expected_bins.push_back(held_item.want);
                else if (produces)
                    expected_bins.push_back(predicted);
                pixels_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pixel_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 7))
                begin
                    held_item = pixel_q.pop_front();
                    in_valid <= 1'b1;
                    sample   <= held_item.pix;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !no_gaps && ($urandom_range(0, 99) < 7);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_bins.size() == 0)
            begin
                $display("%0t: result transaction with none expected, value %h",
                         $time, binned_value);
                errors++;
            end
            else
            begin
                want_bin = expected_bins.pop_front();
                if (binned_value !== want_bin.value)
                begin
                    $display("%0t: binned_value expected %h actual %h",
                             $time, want_bin.value, binned_value);
                    errors++;
                end
                if (row_end !== want_bin.row_end)
                begin
                    $display("%0t: row_end expected %b actual %b",
                             $time, want_bin.row_end, row_end);
                    errors++;
                end
                if (plane_end !== want_bin.plane_end)
                begin
                    $display("%0t: plane_end expected %b actual %b",
                             $time, want_bin.plane_end, plane_end);
                    errors++;
                end
                if (map_end !== want_bin.map_end)
                begin
                    $display("%0t: map_end expected %b actual %b",
                             $time, want_bin.map_end, map_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_bins.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Register write on the plain write port; the shadow copy follows the write.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_PLANE_WIDTH:  reg_width  = val[SIZE_BITS-1:0];
            CFG_PLANE_HEIGHT: reg_height = val[SIZE_BITS-1:0];
            CFG_PLANE_COUNT:  reg_count  = val[COUNT_BITS-1:0];
            CFG_X_EXPONENT:   reg_xexp   = val[EXP_BITS-1:0];
            CFG_Y_EXPONENT:   reg_yexp   = val[EXP_BITS-1:0];
            default: ;
        endcase
    endtask

    // Hold off until every pixel is sent, every result is in and the pipeline is empty.
    task automatic wait_drained();
        while (pixel_q.size() != 0 || in_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame set: rewind the raster counters with a single-pixel map, program
    // the sizes and exponents, then send whole maps.
    task automatic run_frames(input int unsigned w, input int unsigned h, input int unsigned p,
                              input int unsigned xe, input int unsigned ye,
                              input int unsigned maps, input fill_t fill);
        int unsigned            n;
        logic [SAMPLE_BITS-1:0] pix;
        write_reg(CFG_PLANE_WIDTH, 13'd1);
        write_reg(CFG_PLANE_HEIGHT, 13'd1);
        write_reg(CFG_PLANE_COUNT, 13'd1);
        write_reg(CFG_X_EXPONENT, 13'd0);
        write_reg(CFG_Y_EXPONENT, 13'd0);
        pixel_q.push_back('{SAMPLE_BITS'($urandom), 1'b0, '0});
        wait_drained();

        write_reg(CFG_PLANE_WIDTH, CFG_BITS'(w));
        write_reg(CFG_PLANE_HEIGHT, CFG_BITS'(h));
        write_reg(CFG_PLANE_COUNT, CFG_BITS'(p));
        write_reg(CFG_X_EXPONENT, CFG_BITS'(xe));
        write_reg(CFG_Y_EXPONENT, CFG_BITS'(ye));
        n = maps * clamp_size(w, WIDTH_LIMIT) * clamp_size(h, HEIGHT_LIMIT)
            * clamp_size(p, PLANE_LIMIT);
        for (int unsigned i = 0; i < n; i++)
        begin
            case (fill)
                FILL_MAX: pix = 24'h7FFFFF;
                FILL_MIN: pix = 24'h800000;
                FILL_EXTREMES:
                    case ($urandom_range(0, 2))
                        0:       pix = 24'h7FFFFF;
                        1:       pix = 24'h800000;
                        default: pix = SAMPLE_BITS'($urandom);
                    endcase
                default: pix = SAMPLE_BITS'($urandom);
            endcase
            pixel_q.push_back('{pix, 1'b0, '0});
        end
        wait_drained();
        frames_run++;
    endtask

    initial
    begin
        int unsigned xe, ye, n_before;
        fill_t       fill;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; registers change only once the block has gone idle.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end
            else
                pixel_q.push_back('{DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want});
        end
        wait_drained();

        // Largest factors and sizes, each once.
        run_frames(128, 128, 1, 7, 7, 1, FILL_MIN);
        no_gaps = 1'b1;
        run_frames(4096, 2, 1, 0, 1, 1, FILL_RANDOM);
        no_gaps = 1'b0;
        run_frames(1, 4096, 1, 0, 3, 1, FILL_EXTREMES);
        run_frames(2, 2, 256, 1, 1, 1, FILL_RANDOM);
        run_frames(128, 1, 1, 7, 0, 2, FILL_MAX);
        run_frames(1, 128, 2, 0, 7, 1, FILL_EXTREMES);

        // Random small frame sets, mostly small factors, now and then a large one.
        while (random_pixels < 2000)
        begin
            xe = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
            ye = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
            fill = ($urandom_range(0, 7) == 0) ? FILL_EXTREMES : FILL_RANDOM;
            n_before = pixels_accepted;
            run_frames($urandom_range(0, 24), $urandom_range(0, 12), $urandom_range(0, 3),
                       xe, ye, $urandom_range(1, 2), fill);
            random_pixels += pixels_accepted - n_before;
        end
        wait_drained();

        if (expected_bins.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_bins.size());
            errors++;
        end
        $display("Sent %0d pixels over %0d frame sets (%0d in random sets), checked %0d results.",
                 pixels_accepted, frames_run, random_pixels, results_seen);
        $display("Factors from 1 to 128 in each direction, pass-through, partial blocks, %0d errors.",
                 errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
